### hdl/srl_pkg.sv
// Package for the lag-55 subtractive generator: sizes, constants, state codes,
// the fold helper and the structs between the sequencer and the scaling unit.
// No dependencies.
package srl_pkg;

  localparam int TABLE_SIZE = 55;
  localparam int MIX_ROUNDS = 4;
  localparam int LAG_STEP   = 21;
  localparam int MIX_OFFSET = 30;
  localparam int FILL_STEPS = TABLE_SIZE - 1;

  localparam int ADDR_W  = $clog2(TABLE_SIZE + 1);
  localparam int ROUND_W = $clog2(MIX_ROUNDS + 1);
  localparam int DRAW_W  = 31;

  localparam logic [31:0] SEED_BASE = 32'd161803398;
  localparam logic [31:0] MAX_VALUE = 32'h7FFF_FFFF;

  typedef logic [ADDR_W-1:0] srl_addr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_FILL,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_SCALE,
    ST_EMIT
  } srl_state_e;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [DRAW_W-1:0] mag;
    logic [DRAW_W-1:0] bound;
  } srl_scale_req_t;

  typedef struct packed {
    logic              done;
    logic [DRAW_W-1:0] quot;
  } srl_scale_rsp_t;

  // Fold a negative word up by 2^31-1.
  function automatic logic [31:0] fold_neg(logic [31:0] v);
    logic [31:0] r;
    r = v[31] ? (v + MAX_VALUE) : v;
    return r;
  endfunction

endpackage

### hdl/srl_if.sv
// Valid/ready channels of the lag-55 generator: request and response.
// Depends on srl_pkg for the draw width.
interface srl_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] bound;

  modport source (output valid, output func, output bound, input ready);
  modport sink   (input valid, input func, input bound, output ready);
endinterface

interface srl_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [srl_pkg::DRAW_W-1:0] draw;
  logic                      status;

  modport source (output valid, output draw, output status, input ready);
  modport sink   (input valid, input draw, input status, output ready);
endinterface

### hdl/srl_scale.sv
// Scaling unit: floor(mag*bound/(2^31-1)) with sign, three registered stages.
// Depends on srl_pkg for widths and the request/response structs.
module srl_scale (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  srl_pkg::srl_scale_req_t req_i,
  output srl_pkg::srl_scale_rsp_t rsp_o
);

  localparam logic [31:0] TwoMax = {srl_pkg::MAX_VALUE[30:0], 1'b0};

  logic                       v1_q, v2_q, v3_q;
  logic [2*srl_pkg::DRAW_W-1:0] prod_q, prod_d;
  logic                       neg1_q, neg2_q;
  logic [srl_pkg::DRAW_W-1:0] hi_q;
  logic [31:0]                sum_q, sum_d;
  logic [srl_pkg::DRAW_W-1:0] corr;
  logic [srl_pkg::DRAW_W-1:0] quot;
  logic [srl_pkg::DRAW_W-1:0] quot_q, quot_d;

  assign prod_d = {{srl_pkg::DRAW_W{1'b0}}, req_i.mag} * {{srl_pkg::DRAW_W{1'b0}}, req_i.bound};

  // x = hi*2^31 + lo = hi*M + (hi + lo), and hi + lo never exceeds 2M.
  assign sum_d = {1'b0, prod_q[2*srl_pkg::DRAW_W-1:srl_pkg::DRAW_W]}
               + {1'b0, prod_q[srl_pkg::DRAW_W-1:0]};

  always_comb begin
    if (sum_q >= TwoMax) begin
      corr = srl_pkg::DRAW_W'(2);
    end else if (sum_q >= srl_pkg::MAX_VALUE) begin
      corr = srl_pkg::DRAW_W'(1);
    end else begin
      corr = '0;
    end
    quot   = hi_q + corr;
    quot_d = neg2_q ? ('0 - quot) : quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= prod_d;
      neg1_q <= req_i.neg;
    end
    if (v1_q) begin
      hi_q   <= prod_q[2*srl_pkg::DRAW_W-1:srl_pkg::DRAW_W];
      sum_q  <= sum_d;
      neg2_q <= neg1_q;
    end
    if (v2_q) begin
      quot_q <= quot_d;
    end
  end

  assign rsp_o.done = v3_q;
  assign rsp_o.quot = quot_q;

endmodule

### hdl/subtractive_lag55_rng.sv
// Top level of the lag-55 subtractive generator: sequencer, table memory,
// seed register and response register. Depends on srl_pkg, srl_if, srl_scale.
//
// Each accepted request returns one response. A raw draw (func 0) reads the
// leading and trailing words from the dual-read table memory, then subtracts
// and writes back, and its draw goes to the response register. A scaled draw
// (func 1) also passes through the scaling unit (31x31 multiply, then a
// two-step reduction by 2^31-1). A request with func 1 and a negative bound
// gets draw 0 and status 1, formed in its acceptance cycle, and leaves the
// generator untouched. The first request after reset or after a seed write
// first builds the table: the top word, 54 fill writes and 4 mixing passes
// of 55 read/write pairs, all before its draw starts. A seed write clears
// the seeded state and rewinds both indices; write the seed only while idle.
// A finished response waits in its register while the next request is taken.
module subtractive_lag55_rng (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_wdata_i,
  srl_req_if.sink     req_i,
  srl_rsp_if.source   rsp_o
);

  // Sequencer state and the request being worked on.
  srl_pkg::srl_state_e state_q, state_d;
  logic                        func_q, func_d;
  logic [srl_pkg::DRAW_W-1:0]  bound_q, bound_d;

  // Seed magnitude (|seed|, with -2^31 taken as 2^31-1) and the build state.
  logic [srl_pkg::DRAW_W-1:0]  seed_mag_q, seed_mag_d;
  logic [31:0]                 seed_neg;
  logic                        seeded_q, seeded_d;
  srl_pkg::srl_addr_t          lead_q, lead_d, trail_q, trail_d;
  srl_pkg::srl_addr_t          lead_nx, trail_nx;
  srl_pkg::srl_addr_t          pos_q, pos_d, pos_nx;
  logic [srl_pkg::ADDR_W:0]    pos_sum;
  srl_pkg::srl_addr_t          cnt_q, cnt_d;
  logic [31:0]                 mj_q, mj_d, mk_q, mk_d;
  srl_pkg::srl_addr_t          mix_i_q, mix_i_d, mix_j;
  logic [srl_pkg::ADDR_W:0]    mix_sum;
  logic [srl_pkg::ROUND_W-1:0] round_q, round_d;

  // Table memory: two registered read ports, one write port.
  logic [31:0]        mem [srl_pkg::TABLE_SIZE+1];
  logic               rd_en, wr_en;
  srl_pkg::srl_addr_t rd_addr_a, rd_addr_b, wr_addr;
  logic [31:0]        wr_data;
  logic [31:0]        rd_a_q, rd_b_q;

  // Draw datapath.
  logic [31:0] diff, draw_v;

  // Result handoff and response register.
  logic                       form_valid, form_status;
  logic [srl_pkg::DRAW_W-1:0] form_draw;
  logic                       res_status_q, res_status_d;
  logic [srl_pkg::DRAW_W-1:0] res_draw_q, res_draw_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_status_q, out_status_d;
  logic [srl_pkg::DRAW_W-1:0] out_draw_q, out_draw_d;

  srl_pkg::srl_scale_req_t scale_req;
  srl_pkg::srl_scale_rsp_t scale_rsp;

  logic req_fire, req_err, out_free, fill_last, mix_last;

  assign req_fire  = req_i.valid && req_i.ready;
  assign req_err   = req_i.func && req_i.bound[31];
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign fill_last = (cnt_q == srl_pkg::ADDR_W'(srl_pkg::FILL_STEPS - 1));
  assign mix_last  = (mix_i_q == srl_pkg::ADDR_W'(srl_pkg::TABLE_SIZE))
                  && (round_q == srl_pkg::ROUND_W'(srl_pkg::MIX_ROUNDS - 1));

  // Advance both indices, wrapping from the top entry back to entry 1.
  assign lead_nx  = (lead_q == srl_pkg::ADDR_W'(srl_pkg::TABLE_SIZE))
                  ? srl_pkg::ADDR_W'(1) : lead_q + srl_pkg::ADDR_W'(1);
  assign trail_nx = (trail_q == srl_pkg::ADDR_W'(srl_pkg::TABLE_SIZE))
                  ? srl_pkg::ADDR_W'(1) : trail_q + srl_pkg::ADDR_W'(1);

  // Fill position steps by the lag modulo the table size.
  assign pos_sum = {1'b0, pos_q} + (srl_pkg::ADDR_W + 1)'(srl_pkg::LAG_STEP);
  assign pos_nx  = (pos_sum >= (srl_pkg::ADDR_W + 1)'(srl_pkg::TABLE_SIZE))
                 ? srl_pkg::ADDR_W'(pos_sum - (srl_pkg::ADDR_W + 1)'(srl_pkg::TABLE_SIZE))
                 : pos_sum[srl_pkg::ADDR_W-1:0];

  // Mixing partner of entry i: 1 + ((i + offset) mod size).
  assign mix_sum = {1'b0, mix_i_q} + (srl_pkg::ADDR_W + 1)'(srl_pkg::MIX_OFFSET);
  assign mix_j   = (mix_sum >= (srl_pkg::ADDR_W + 1)'(srl_pkg::TABLE_SIZE))
                 ? srl_pkg::ADDR_W'(mix_sum - (srl_pkg::ADDR_W + 1)'(srl_pkg::TABLE_SIZE - 1))
                 : srl_pkg::ADDR_W'(mix_sum + (srl_pkg::ADDR_W + 1)'(1));

  // Draw value: map 2^31-1 to 2^31-2, else fold negatives.
  assign diff   = rd_a_q - rd_b_q;
  assign draw_v = (diff == srl_pkg::MAX_VALUE) ? (srl_pkg::MAX_VALUE - 32'd1)
                                               : srl_pkg::fold_neg(diff);

  assign seed_neg = 32'd0 - seed_wdata_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srl_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (req_err) begin
            state_d = out_free ? srl_pkg::ST_IDLE : srl_pkg::ST_EMIT;
          end else if (seeded_q) begin
            state_d = srl_pkg::ST_DRAW_WR;
          end else begin
            state_d = srl_pkg::ST_SEED;
          end
        end
      end
      srl_pkg::ST_SEED: begin
        state_d = srl_pkg::ST_FILL;
      end
      srl_pkg::ST_FILL: begin
        if (fill_last) begin
          state_d = srl_pkg::ST_MIX_RD;
        end
      end
      srl_pkg::ST_MIX_RD: begin
        state_d = srl_pkg::ST_MIX_WR;
      end
      srl_pkg::ST_MIX_WR: begin
        state_d = mix_last ? srl_pkg::ST_DRAW_RD : srl_pkg::ST_MIX_RD;
      end
      srl_pkg::ST_DRAW_RD: begin
        state_d = srl_pkg::ST_DRAW_WR;
      end
      srl_pkg::ST_DRAW_WR: begin
        if (func_q) begin
          state_d = srl_pkg::ST_SCALE;
        end else begin
          state_d = out_free ? srl_pkg::ST_IDLE : srl_pkg::ST_EMIT;
        end
      end
      srl_pkg::ST_SCALE: begin
        if (scale_rsp.done) begin
          state_d = out_free ? srl_pkg::ST_IDLE : srl_pkg::ST_EMIT;
        end
      end
      srl_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = srl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srl_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath. Every table read is followed by its write-back
  // cycle, so no read ever overlaps a pending write: no forwarding.
  always_comb begin
    req_i.ready = 1'b0;
    rd_en       = 1'b0;
    rd_addr_a   = lead_q;
    rd_addr_b   = trail_q;
    wr_en       = 1'b0;
    wr_addr     = lead_q;
    wr_data     = draw_v;
    form_valid  = 1'b0;
    form_status = 1'b0;
    form_draw   = '0;
    scale_req.start = 1'b0;
    scale_req.neg   = draw_v[31];
    // Only the folded minimum (-1) is negative in the table.
    scale_req.mag   = draw_v[31] ? srl_pkg::DRAW_W'(1) : draw_v[30:0];
    scale_req.bound = bound_q;

    func_d     = func_q;
    bound_d    = bound_q;
    seed_mag_d = seed_mag_q;
    seeded_d   = seeded_q;
    lead_d     = lead_q;
    trail_d    = trail_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    mj_d       = mj_q;
    mk_d       = mk_q;
    mix_i_d    = mix_i_q;
    round_d    = round_q;

    case (state_q)
      srl_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_fire) begin
          func_d  = req_i.func;
          bound_d = req_i.bound[30:0];
          if (req_err) begin
            // Reject: answer now, leave the generator alone.
            form_valid  = 1'b1;
            form_status = 1'b1;
          end else if (seeded_q) begin
            rd_en     = 1'b1;
            rd_addr_a = lead_nx;
            rd_addr_b = trail_nx;
            lead_d    = lead_nx;
            trail_d   = trail_nx;
          end
        end
      end
      srl_pkg::ST_SEED: begin
        wr_en   = 1'b1;
        wr_addr = srl_pkg::ADDR_W'(srl_pkg::TABLE_SIZE);
        wr_data = srl_pkg::SEED_BASE - {1'b0, seed_mag_q};
        mj_d    = wr_data;
        mk_d    = 32'd1;
        pos_d   = '0;
        cnt_d   = '0;
      end
      srl_pkg::ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = pos_nx;
        wr_data = mk_q;
        mk_d    = srl_pkg::fold_neg(mj_q - mk_q);
        mj_d    = mk_q;
        pos_d   = pos_nx;
        cnt_d   = cnt_q + srl_pkg::ADDR_W'(1);
        if (fill_last) begin
          mix_i_d = srl_pkg::ADDR_W'(1);
          round_d = '0;
        end
      end
      srl_pkg::ST_MIX_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = mix_i_q;
        rd_addr_b = mix_j;
      end
      srl_pkg::ST_MIX_WR: begin
        wr_en   = 1'b1;
        wr_addr = mix_i_q;
        wr_data = srl_pkg::fold_neg(diff);
        if (mix_i_q == srl_pkg::ADDR_W'(srl_pkg::TABLE_SIZE)) begin
          mix_i_d = srl_pkg::ADDR_W'(1);
          round_d = round_q + srl_pkg::ROUND_W'(1);
        end else begin
          mix_i_d = mix_i_q + srl_pkg::ADDR_W'(1);
        end
        if (mix_last) begin
          seeded_d = 1'b1;
        end
      end
      srl_pkg::ST_DRAW_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = lead_nx;
        rd_addr_b = trail_nx;
        lead_d    = lead_nx;
        trail_d   = trail_nx;
      end
      srl_pkg::ST_DRAW_WR: begin
        wr_en   = 1'b1;
        wr_addr = lead_q;
        wr_data = draw_v;
        if (func_q) begin
          scale_req.start = 1'b1;
        end else begin
          form_valid = 1'b1;
          form_draw  = draw_v[30:0];
        end
      end
      srl_pkg::ST_SCALE: begin
        if (scale_rsp.done) begin
          form_valid = 1'b1;
          form_draw  = scale_rsp.quot;
        end
      end
      srl_pkg::ST_EMIT: begin
        // Hold the parked result until the response register frees up.
      end
      default: begin
      end
    endcase

    // Seed write: rewind and force a rebuild on the next request.
    if (seed_we_i) begin
      if (seed_wdata_i == 32'h8000_0000) begin
        seed_mag_d = srl_pkg::MAX_VALUE[30:0];
      end else if (seed_wdata_i[31]) begin
        seed_mag_d = seed_neg[30:0];
      end else begin
        seed_mag_d = seed_wdata_i[30:0];
      end
      seeded_d = 1'b0;
      lead_d   = '0;
      trail_d  = srl_pkg::ADDR_W'(srl_pkg::LAG_STEP);
    end
  end

  // Response register: load a fresh result when free, else park it.
  always_comb begin
    res_draw_d   = res_draw_q;
    res_status_d = res_status_q;
    out_draw_d   = out_draw_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    if (state_q == srl_pkg::ST_EMIT && out_free) begin
      out_valid_d  = 1'b1;
      out_draw_d   = res_draw_q;
      out_status_d = res_status_q;
    end else if (form_valid && out_free) begin
      out_valid_d  = 1'b1;
      out_draw_d   = form_draw;
      out_status_d = form_status;
    end else if (form_valid) begin
      res_draw_d   = form_draw;
      res_status_d = form_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srl_pkg::ST_IDLE;
      seed_mag_q  <= '0;
      seeded_q    <= 1'b0;
      lead_q      <= '0;
      trail_q     <= srl_pkg::ADDR_W'(srl_pkg::LAG_STEP);
      pos_q       <= '0;
      cnt_q       <= '0;
      mix_i_q     <= srl_pkg::ADDR_W'(1);
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_mag_q  <= seed_mag_d;
      seeded_q    <= seeded_d;
      lead_q      <= lead_d;
      trail_q     <= trail_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      mix_i_q     <= mix_i_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    bound_q      <= bound_d;
    mj_q         <= mj_d;
    mk_q         <= mk_d;
    res_draw_q   <= res_draw_d;
    res_status_q <= res_status_d;
    out_draw_q   <= out_draw_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_a_q <= mem[rd_addr_a];
      rd_b_q <= mem[rd_addr_b];
    end
  end

  srl_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scale_req),
    .rsp_o  (scale_rsp)
  );

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.draw   = out_draw_q;
  assign rsp_o.status = out_status_q;

  // The scaling unit finishes only while the sequencer waits for it.
  a_scale_done_in_scale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_rsp.done |-> state_q == srl_pkg::ST_SCALE)
    else $error("scale result outside the scale wait");

  // Table writes stay within entries 1 to TABLE_SIZE.
  a_wr_addr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr != '0) && (wr_addr <= srl_pkg::ADDR_W'(srl_pkg::TABLE_SIZE)))
    else $error("table write outside entries 1..TABLE_SIZE");

  // A draw writes back to an advanced, in-range lead index.
  a_lead_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == srl_pkg::ST_DRAW_WR |->
      (lead_q != '0) && (lead_q <= srl_pkg::ADDR_W'(srl_pkg::TABLE_SIZE)))
    else $error("draw write-back with lead index out of range");

  // A rejected request leaves the indices as they were.
  a_reject_no_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_err && !seed_we_i) |=>
      (lead_q == $past(lead_q)) && (trail_q == $past(trail_q))
      && (state_q == srl_pkg::ST_IDLE || state_q == srl_pkg::ST_EMIT))
    else $error("rejected request advanced the generator");

endmodule
